/* rtl/sbeq_pkg.sv */
// Shared types and field layout for the sensor bitmap event queues.
`default_nettype none

package sbeq_pkg;

  // Request kinds carried on in_tuser.
  typedef enum logic [1:0] {
    FUNC_REPORT = 2'd0,
    FUNC_PUSH   = 2'd1,
    FUNC_POP    = 2'd2
  } func_t;

  // Result status carried in the low bits of out_tuser.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MODULE = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  // Input tdata layout, lowest bit first.
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_IDX_W    = 4;
  localparam int IN_BYTE_LSB = IN_IDX_LSB + IN_IDX_W;
  localparam int IN_BYTE_W   = 8;
  localparam int IN_CODE_LSB = IN_BYTE_LSB + IN_BYTE_W;
  localparam int IN_CODE_W   = 3;
  localparam int IN_NUM_LSB  = IN_CODE_LSB + IN_CODE_W;
  localparam int IN_NUM_W    = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;

  // Output tdata layout, lowest bit first.
  localparam int OUT_MOD_W    = 3;
  localparam int OUT_NUM_W    = 8;
  localparam int OUT_TDATA_W  = 16;
  localparam int OUT_TUSER_W  = 3;
  localparam int OUT_FOUND_BIT = 2;

endpackage

`default_nettype wire

/* rtl/sensor_bitmap_event_queues.sv */
// Top level: per-module sensor event FIFOs held in one shared memory.
`default_nettype none

// The block keeps one FIFO of sensor numbers for each sensor module, all
// FIFOs sharing a single synchronous memory of NUM_MODULES*FIFO_DEPTH bytes
// with a registered read. Three request kinds arrive on the input
// stream: a report byte unpacks a bitmap and pushes one sensor number per set
// bit (bit 7 first), a direct push queues one number, and a pop returns the
// oldest event of the first non-empty module in fixed order, module A first.
// Every request yields exactly one result. Requests are handled one at a time
// by a small sequencer around the single memory port. A report byte passes
// the report state, one memory write slot per bitmap bit, eight in all; a
// direct push the push state; a pop that finds an event the pop state (memory
// read) and the pop data state (its registered data); a pop of empty queues
// the pop state; a request naming a missing module or the unused kind goes
// straight to the finish state. A stalled output holds the sequencer there,
// although the next request is accepted while a finished result still sits
// in the output register. The memory needs no clearing after reset: every
// read is guarded by the per-module fill count, which reset clears.
module sensor_bitmap_event_queues #(
  parameter int NUM_MODULES = 5,
  parameter int FIFO_DEPTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // byte_index[3:0], byte_value[11:4], module_code[14:12],
  // sensor_number[22:15], zero pad [23]
  input  wire logic [sbeq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [sbeq_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // module_out[2:0], number_out[10:3], zero pad [15:11]
  output logic [sbeq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0], found[2]
  output logic [sbeq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int MW        = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
  localparam int PW        = $clog2(FIFO_DEPTH);
  localparam int CW        = $clog2(FIFO_DEPTH + 1);
  localparam int DEPTH_ALL = NUM_MODULES * FIFO_DEPTH;
  localparam int AW        = $clog2(DEPTH_ALL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REPORT,
    S_PUSH,
    S_POP,
    S_POP_DATA,
    S_FINISH
  } state_t;

  // Input fields.
  logic [sbeq_pkg::IN_IDX_W-1:0]  in_byte_index;
  logic [sbeq_pkg::IN_BYTE_W-1:0] in_byte_value;
  logic [sbeq_pkg::IN_CODE_W-1:0] in_module_code;
  logic [sbeq_pkg::IN_NUM_W-1:0]  in_sensor_number;
  logic [7:0]                     idx_mod_ext;
  logic [7:0]                     code_ext;

  assign in_byte_index    = in_tdata[sbeq_pkg::IN_IDX_LSB +: sbeq_pkg::IN_IDX_W];
  assign in_byte_value    = in_tdata[sbeq_pkg::IN_BYTE_LSB +: sbeq_pkg::IN_BYTE_W];
  assign in_module_code   = in_tdata[sbeq_pkg::IN_CODE_LSB +: sbeq_pkg::IN_CODE_W];
  assign in_sensor_number = in_tdata[sbeq_pkg::IN_NUM_LSB +: sbeq_pkg::IN_NUM_W];
  assign idx_mod_ext      = 8'(in_byte_index[3:1]);
  assign code_ext         = 8'(in_module_code);

  // Sequencer state.
  state_t                  state_r, state_nxt;
  logic [MW-1:0]           cur_mod_r, cur_mod_nxt;
  logic                    half_r, half_nxt;
  logic [7:0]              bits_r, bits_nxt;
  logic [2:0]              bit_cnt_r, bit_cnt_nxt;
  logic [7:0]              num_r, num_nxt;

  // Per-module queue pointers.
  logic [PW-1:0]           head_r  [NUM_MODULES];
  logic [PW-1:0]           head_nxt[NUM_MODULES];
  logic [PW-1:0]           tail_r  [NUM_MODULES];
  logic [PW-1:0]           tail_nxt[NUM_MODULES];
  logic [CW-1:0]           count_r  [NUM_MODULES];
  logic [CW-1:0]           count_nxt[NUM_MODULES];

  // Pending result and output register.
  sbeq_pkg::status_t       res_status_r, res_status_nxt;
  logic                    res_found_r, res_found_nxt;
  logic [2:0]              res_mod_r, res_mod_nxt;
  logic [7:0]              res_num_r, res_num_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [sbeq_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [sbeq_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // Memory port.
  logic [7:0]              mem [DEPTH_ALL];
  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_addr;
  logic [7:0]              mem_wdata;
  logic [7:0]              mem_rdata_r;

  // Pop scan: first module with a non-zero fill count.
  logic                    pop_any;
  logic [MW-1:0]           pop_idx;
  logic [MW-1:0]           sel_mod;
  logic                    sel_full;
  logic [AW-1:0]           sel_base;
  logic [7:0]              pop_idx_ext;

  always_comb begin
    pop_any = 1'b0;
    pop_idx = '0;
    for (int m = NUM_MODULES - 1; m >= 0; m--) begin
      if (count_r[m] != '0) begin
        pop_any = 1'b1;
        pop_idx = MW'(m);
      end
    end
  end

  assign pop_idx_ext = 8'(pop_idx);
  assign sel_mod     = (state_r == S_POP) ? pop_idx : cur_mod_r;
  assign sel_full    = (count_r[sel_mod] == CW'(FIFO_DEPTH));
  assign sel_base    = AW'(int'(sel_mod) * FIFO_DEPTH);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt      = state_r;
    cur_mod_nxt    = cur_mod_r;
    half_nxt       = half_r;
    bits_nxt       = bits_r;
    bit_cnt_nxt    = bit_cnt_r;
    num_nxt        = num_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_mod_nxt    = res_mod_r;
    res_num_nxt    = res_num_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = '0;
    mem_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_status_nxt = sbeq_pkg::ST_OK;
          res_found_nxt  = 1'b0;
          res_mod_nxt    = '0;
          res_num_nxt    = '0;
          unique case (in_tuser)
            sbeq_pkg::FUNC_REPORT: begin
              if (int'(idx_mod_ext) >= NUM_MODULES) begin
                res_status_nxt = sbeq_pkg::ST_BAD_MODULE;
                state_nxt      = S_FINISH;
              end else begin
                cur_mod_nxt = idx_mod_ext[MW-1:0];
                half_nxt    = in_byte_index[0];
                bits_nxt    = in_byte_value;
                bit_cnt_nxt = '0;
                state_nxt   = S_REPORT;
              end
            end
            sbeq_pkg::FUNC_PUSH: begin
              if (int'(code_ext) >= NUM_MODULES) begin
                res_status_nxt = sbeq_pkg::ST_BAD_MODULE;
                state_nxt      = S_FINISH;
              end else begin
                cur_mod_nxt = code_ext[MW-1:0];
                num_nxt     = in_sensor_number;
                state_nxt   = S_PUSH;
              end
            end
            sbeq_pkg::FUNC_POP: begin
              state_nxt = S_POP;
            end
            default: begin
              // Unused request kind: nothing changes, an all-zero result.
              state_nxt = S_FINISH;
            end
          endcase
        end
      end

      S_REPORT: begin
        // One bitmap bit per cycle, most significant first.
        if (bits_r[7]) begin
          if (sel_full) begin
            res_status_nxt = sbeq_pkg::ST_FULL;
          end else begin
            mem_we              = 1'b1;
            mem_addr            = sel_base + AW'(tail_r[sel_mod]);
            mem_wdata           = 8'({half_r, bit_cnt_r}) + 8'd1;
            tail_nxt[sel_mod]   = (tail_r[sel_mod] == PW'(FIFO_DEPTH - 1)) ?
                                  '0 : tail_r[sel_mod] + 1'b1;
            count_nxt[sel_mod]  = count_r[sel_mod] + 1'b1;
          end
        end
        bits_nxt    = {bits_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          state_nxt = S_FINISH;
        end
      end

      S_PUSH: begin
        if (sel_full) begin
          res_status_nxt = sbeq_pkg::ST_FULL;
        end else begin
          mem_we             = 1'b1;
          mem_addr           = sel_base + AW'(tail_r[sel_mod]);
          mem_wdata          = num_r;
          tail_nxt[sel_mod]  = (tail_r[sel_mod] == PW'(FIFO_DEPTH - 1)) ?
                               '0 : tail_r[sel_mod] + 1'b1;
          count_nxt[sel_mod] = count_r[sel_mod] + 1'b1;
        end
        state_nxt = S_FINISH;
      end

      S_POP: begin
        if (!pop_any) begin
          res_status_nxt = sbeq_pkg::ST_EMPTY;
          state_nxt      = S_FINISH;
        end else begin
          mem_re             = 1'b1;
          mem_addr           = sel_base + AW'(head_r[sel_mod]);
          head_nxt[sel_mod]  = (head_r[sel_mod] == PW'(FIFO_DEPTH - 1)) ?
                               '0 : head_r[sel_mod] + 1'b1;
          count_nxt[sel_mod] = count_r[sel_mod] - 1'b1;
          res_found_nxt      = 1'b1;
          res_mod_nxt        = pop_idx_ext[2:0];
          state_nxt          = S_POP_DATA;
        end
      end

      S_POP_DATA: begin
        res_num_nxt = mem_rdata_r;
        state_nxt   = S_FINISH;
      end

      S_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'b0, res_num_r, res_mod_r};
          out_tuser_nxt  = {res_found_r, res_status_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      bit_cnt_r    <= '0;
      for (int m = 0; m < NUM_MODULES; m++) begin
        head_r[m]  <= '0;
        tail_r[m]  <= '0;
        count_r[m] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
    end
    cur_mod_r    <= cur_mod_nxt;
    half_r       <= half_nxt;
    bits_r       <= bits_nxt;
    num_r        <= num_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_mod_r    <= res_mod_nxt;
    res_num_r    <= res_num_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  // Queue storage: one port, write or registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sbeq_checker.sv */
// Port-level checks for the sensor bitmap event queues, bound to the top level.
`default_nettype none

module sbeq_checker #(
  parameter int NUM_MODULES = 5
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [sbeq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [sbeq_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  // A result that waits keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A returned event always carries the ok status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[sbeq_pkg::OUT_FOUND_BIT] |->
      out_tuser[1:0] == sbeq_pkg::ST_OK)
    else $error("event returned with a failure status");

  // Without an event, module and number read as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[sbeq_pkg::OUT_FOUND_BIT] |-> out_tdata == '0)
    else $error("result without an event carries data");

  // A returned event names an existing module.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[sbeq_pkg::OUT_FOUND_BIT] |->
      int'(out_tdata[sbeq_pkg::OUT_MOD_W-1:0]) < NUM_MODULES)
    else $error("event from a module that does not exist");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind sensor_bitmap_event_queues sbeq_checker #(.NUM_MODULES(NUM_MODULES)) u_sbeq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
